### hdl/density_gated_random_value_core_defines.svh
// Assertion macros shared by the density gated random value core.
// No dependencies; included by the modules that carry assertions.
`ifndef DENSITY_GATED_RANDOM_VALUE_CORE_DEFINES_SVH
`define DENSITY_GATED_RANDOM_VALUE_CORE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define DGRV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dgrv assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define DGRV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dgrv assertion failed");

`endif

### hdl/dgrv_pkg.sv
// Package for the density gated random value core: widths, generator constants,
// and the command/status structs between controller and datapath. No dependencies.
package dgrv_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int VAL_W      = FRAC_BITS + 1;
    localparam int DIFF_W     = VAL_W + 1;
    localparam int SPROD_W    = VAL_W + DIFF_W;

    localparam int STATE_W    = 31;
    localparam int MUL_W      = 16;
    localparam int PROD_W     = STATE_W + MUL_W;
    localparam int FRAC_SHIFT = STATE_W - FRAC_BITS;

    localparam logic [VAL_W-1:0]   ONE_Q       = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [MUL_W-1:0]   LEHMER_MUL  = 16'd48271;
    localparam logic [STATE_W-1:0] LEHMER_MOD  = 31'h7FFF_FFFF;
    localparam logic [STATE_W-1:0] LEHMER_SEED = 31'd1;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic red;
        logic test;
        logic frac;
        logic scale;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic out_free;
    } t_sts;

endpackage

### hdl/dgrv_dp.sv
// Datapath: Lehmer generator with shared multiply and Mersenne fold, density
// register, range scaling and output word register. Depends on dgrv_pkg.
`include "density_gated_random_value_core_defines.svh"

module dgrv_dp import dgrv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_cfg_valid,
    input  logic [VAL_W-1:0] i_cfg_density,
    input  logic [VAL_W-1:0] i_range_low,
    input  logic [VAL_W-1:0] i_range_center,
    input  logic [VAL_W-1:0] i_range_high,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [VAL_W-1:0] o_value,
    output logic             o_replaced
);

    logic [STATE_W-1:0]       r_state;
    logic [VAL_W-1:0]         r_density;
    logic [PROD_W-1:0]        r_prod;
    logic [FRAC_BITS-1:0]     r_frac;
    logic [VAL_W-1:0]         r_lo;
    logic [VAL_W-1:0]         r_center;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [SPROD_W-1:0] r_sprod;
    logic                     r_rep;
    logic                     r_out_valid;
    logic [VAL_W-1:0]         r_value;
    logic                     r_replaced;

    logic [STATE_W:0]         fold_sum;
    logic [STATE_W:0]         fold_red;
    logic [STATE_W-1:0]       x_m1;
    logic [FRAC_BITS-1:0]     frac_c;
    logic [VAL_W-1:0]         rand_val;
    logic [VAL_W-1:0]         n_density;

    // x*48271 mod (2^31-1): fold high part onto low part, one conditional subtract
    assign fold_sum = {{(STATE_W+1-(PROD_W-STATE_W)){1'b0}}, r_prod[PROD_W-1:STATE_W]}
                    + {1'b0, r_prod[STATE_W-1:0]};
    assign fold_red = (fold_sum >= {1'b0, LEHMER_MOD}) ? fold_sum - {1'b0, LEHMER_MOD}
                                                       : fold_sum;

    assign x_m1   = r_state - LEHMER_SEED;
    assign frac_c = x_m1[STATE_W-1:FRAC_SHIFT];

    assign rand_val  = r_lo + r_sprod[FRAC_BITS +: VAL_W];
    assign n_density = (i_cfg_density > ONE_Q) ? ONE_Q : i_cfg_density;

    assign o_sts.hit      = ({1'b0, frac_c} < r_density);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= LEHMER_SEED;
            r_density   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_density <= n_density;
            end
            if (i_cmd.red) begin
                r_state <= fold_red[STATE_W-1:0];
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_lo     <= i_range_low;
            r_center <= i_range_center;
            r_diff   <= $signed({1'b0, i_range_high}) - $signed({1'b0, i_range_low});
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_state) * PROD_W'(LEHMER_MUL);
        end
        if (i_cmd.test) begin
            r_rep <= o_sts.hit;
        end
        if (i_cmd.frac) begin
            r_frac <= frac_c;
        end
        if (i_cmd.scale) begin
            r_sprod <= SPROD_W'($signed({1'b0, r_frac})) * SPROD_W'(r_diff);
        end
        if (i_cmd.load_out) begin
            r_value    <= r_rep ? rand_val : r_center;
            r_replaced <= r_rep;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_replaced  = r_replaced;

    `DGRV_ASSERT_NOW(a_state_nonzero, 1'b1, (r_state != '0) && (r_state != LEHMER_MOD))
    `DGRV_ASSERT_NOW(a_density_sat, 1'b1, r_density <= ONE_Q)
    `DGRV_ASSERT_NOW(a_no_overwrite, i_cmd.load_out, !r_out_valid || i_out_ready)
    `DGRV_ASSERT_NEXT(a_red_moves, i_cmd.red, r_state != $past(r_state))

endmodule

### hdl/dgrv_ctrl.sv
// Controller: one-hot sequencer over the draw, test, second draw, scale and
// output steps. Depends on dgrv_pkg.
`include "density_gated_random_value_core_defines.svh"

module dgrv_ctrl import dgrv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_MUL1  = 9'b0_0000_0010,
        S_RED1  = 9'b0_0000_0100,
        S_TEST  = 9'b0_0000_1000,
        S_MUL2  = 9'b0_0001_0000,
        S_RED2  = 9'b0_0010_0000,
        S_FRAC2 = 9'b0_0100_0000,
        S_SCALE = 9'b0_1000_0000,
        S_DONE  = 9'b1_0000_0000
    } t_state;

    t_state r_st;
    t_state n_st;

    always_comb begin
        n_st  = r_st;
        o_cmd = '0;
        case (r_st)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) n_st = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul = 1'b1;
                n_st      = S_RED1;
            end
            S_RED1: begin
                o_cmd.red = 1'b1;
                n_st      = S_TEST;
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                n_st       = i_sts.hit ? S_MUL2 : S_DONE;
            end
            S_MUL2: begin
                o_cmd.mul = 1'b1;
                n_st      = S_RED2;
            end
            S_RED2: begin
                o_cmd.red = 1'b1;
                n_st      = S_FRAC2;
            end
            S_FRAC2: begin
                o_cmd.frac = 1'b1;
                n_st       = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_st        = S_DONE;
            end
            S_DONE: begin
                o_cmd.load_out = i_sts.out_free;
                if (i_sts.out_free) n_st = S_IDLE;
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_in_ready = (r_st == S_IDLE) && i_rst_n;

    `DGRV_ASSERT_NEXT(a_accept_starts, i_in_valid && o_in_ready, r_st == S_MUL1)
    `DGRV_ASSERT_NOW(a_single_cmd, 1'b1, $onehot0(o_cmd))
    `DGRV_ASSERT_NEXT(a_miss_to_done, (r_st == S_TEST) && !i_sts.hit, r_st == S_DONE)

endmodule

### hdl/density_gated_random_value_core.sv
// Density gated random value core: minimal-standard Lehmer generator gating center vs range.
// Sequence: accept, draw, density test; a miss writes the center to the output word, a hit
// writes a second draw scaled into the range. The next range waits until the word is written.
// The output register lets the next word be accepted while a result waits.
// Reset (synchronous, active low): generator seed 1, density 0, output empty.
// Depends on dgrv_pkg, dgrv_ctrl, dgrv_dp.
module density_gated_random_value_core import dgrv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [VAL_W-1:0] i_cfg_density,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [VAL_W-1:0] i_range_low,
    input  logic [VAL_W-1:0] i_range_center,
    input  logic [VAL_W-1:0] i_range_high,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [VAL_W-1:0] o_value,
    output logic             o_replaced
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = i_rst_n;

    dgrv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dgrv_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_density  (i_cfg_density),
        .i_range_low    (i_range_low),
        .i_range_center (i_range_center),
        .i_range_high   (i_range_high),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_value        (o_value),
        .o_replaced     (o_replaced)
    );

endmodule
